### src/member_set_with_selection_unit_defines.svh
// Assertion macros shared by the member set unit RTL.
`ifndef MEMBER_SET_WITH_SELECTION_UNIT_DEFINES_SVH
`define MEMBER_SET_WITH_SELECTION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define MSS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("member set unit: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define MSS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("member set unit: next-cycle check failed");

`endif

### src/mss_pkg.sv
// Types and constants shared by the member set unit.
`default_nettype none

package mss_pkg;

  // Table size and derived widths.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 64;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned MCNT_W   = 5;
  localparam int unsigned CTR_W    = 32;
  localparam int unsigned EV_NUM   = 8;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_REMOVE   = 3'd1,
    MODE_TEST     = 3'd2,
    MODE_SELECT   = 3'd3,
    MODE_DESELECT = 3'd4,
    MODE_ACTIVE   = 3'd5,
    MODE_ACK      = 3'd6,
    MODE_CLEAR    = 3'd7
  } mode_e;

  // Event counter slots.
  typedef enum logic [2:0] {
    EV_ADDED        = 3'd0,
    EV_REMOVED      = 3'd1,
    EV_SELECTED     = 3'd2,
    EV_DESELECTED   = 3'd3,
    EV_BAD_SELECT   = 3'd4,
    EV_BAD_DESELECT = 3'd5,
    EV_NOT_ACTIVE   = 3'd6,
    EV_NOT_MEMBER   = 3'd7
  } ev_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_COMMIT = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and restart the search
    logic issue;   // read the table entry under the scan pointer
    logic commit;  // apply the request and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;  // incoming request has to search the table
    logic scan_last;   // scan pointer sits on the last entry
    logic out_free;    // result register can take a new result
  } sts_t;

  // One result.
  typedef struct packed {
    logic                           accepted;
    logic                           table_full;
    logic [ID_W-1:0]                current_selection;
    logic [MCNT_W-1:0]              member_count;
    logic [EV_NUM-1:0][CTR_W-1:0]   totals;
  } rsp_t;

endpackage

`default_nettype wire

### src/mss_req_if.sv
// Request channel: mode and identifier with a valid/ready handshake.
`default_nettype none

interface mss_req_if;
  import mss_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   ident;

  modport source (output valid, output mode, output ident, input ready);
  modport sink (input valid, input mode, input ident, output ready);
endinterface

`default_nettype wire

### src/mss_rsp_if.sv
// Result channel: status, selection, member count and event totals.
`default_nettype none

interface mss_rsp_if;
  import mss_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic              table_full;
  logic [ID_W-1:0]   current_selection;
  logic [MCNT_W-1:0] member_count;
  logic [CTR_W-1:0]  added_total;
  logic [CTR_W-1:0]  removed_total;
  logic [CTR_W-1:0]  selected_total;
  logic [CTR_W-1:0]  deselected_total;
  logic [CTR_W-1:0]  bad_select_total;
  logic [CTR_W-1:0]  bad_deselect_total;
  logic [CTR_W-1:0]  not_active_total;
  logic [CTR_W-1:0]  not_member_total;

  modport source (
    output valid, output accepted, output table_full, output current_selection,
    output member_count, output added_total, output removed_total,
    output selected_total, output deselected_total, output bad_select_total,
    output bad_deselect_total, output not_active_total, output not_member_total,
    input ready
  );
  modport sink (
    input valid, input accepted, input table_full, input current_selection,
    input member_count, input added_total, input removed_total,
    input selected_total, input deselected_total, input bad_select_total,
    input bad_deselect_total, input not_active_total, input not_member_total,
    output ready
  );
endinterface

`default_nettype wire

### src/mss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/mss_datapath.sv
// Datapath: identifier table, valid bits, selection, counters and result register.
`default_nettype none

module mss_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [mss_pkg::MODE_W-1:0] mode_i,
  input  wire logic [mss_pkg::ID_W-1:0]   ident_i,
  input  wire mss_pkg::cmd_t              cmd_i,
  output mss_pkg::sts_t                   sts_o,
  mss_rsp_if.source                       rsp_o
);
  import mss_pkg::*;

  // Captured request.
  mode_e             mode_q;
  logic [ID_W-1:0]   ident_q;

  // Search state.
  logic [IDX_W-1:0]  scan_idx_q;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic              free_fnd_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic [ID_W-1:0]   ram_rdata;
  logic              entry_match;

  // Architectural state.
  logic [CAPACITY-1:0]          valid_q, valid_d;
  logic [ID_W-1:0]              sel_q, sel_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [EV_NUM-1:0][CTR_W-1:0] ev_q, ev_d;

  // Result register.
  rsp_t              rsp_q;
  logic              out_vld_q, out_vld_d;
  logic              ok;
  logic              full;
  logic              ram_we;
  mode_e             mode_in;

  // Capture the request payload when a transaction is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      ident_q <= ident_i;
    end
  end

  // Identifier table; the scan pointer drives the read address.
  mss_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (ident_q),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  assign entry_match = pend_q && valid_q[pend_idx_q] && (ram_rdata == ident_q);

  // Sequential search: one read issued per cycle, compared in the cycle after its issue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_fnd_q <= 1'b0;
      free_idx_q <= '0;
    end else if (cmd_i.load) begin
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.issue;
      if (cmd_i.issue) begin
        pend_idx_q <= scan_idx_q;
        if (!sts_o.scan_last) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (!valid_q[scan_idx_q] && !free_fnd_q) begin
          free_fnd_q <= 1'b1;
          free_idx_q <= scan_idx_q;
        end
      end
      if (entry_match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= pend_idx_q;
      end
    end
  end

  // Request execution; state only moves on commit.
  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    count_d = count_q;
    ev_d    = ev_q;
    ok      = 1'b0;
    full    = 1'b0;
    ram_we  = 1'b0;
    if (cmd_i.commit) begin
      case (mode_q)
        MODE_ADD: begin
          if (hit_q) begin
            sel_d = ident_q;
            ok    = 1'b1;
          end else if (free_fnd_q) begin
            ram_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            count_d             = count_q + CNT_W'(1);
            ev_d[EV_ADDED]      = ev_q[EV_ADDED] + CTR_W'(1);
            sel_d               = ident_q;
            ok                  = 1'b1;
          end else begin
            full = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            count_d            = count_q - CNT_W'(1);
            ev_d[EV_REMOVED]   = ev_q[EV_REMOVED] + CTR_W'(1);
            if (sel_q == ident_q) begin
              sel_d = '0;
            end
            ok = 1'b1;
          end
        end
        MODE_TEST: begin
          ok = hit_q;
        end
        MODE_SELECT: begin
          if (hit_q) begin
            sel_d             = ident_q;
            ev_d[EV_SELECTED] = ev_q[EV_SELECTED] + CTR_W'(1);
            ok                = 1'b1;
          end else begin
            ev_d[EV_BAD_SELECT] = ev_q[EV_BAD_SELECT] + CTR_W'(1);
          end
        end
        MODE_DESELECT: begin
          if ((ident_q != '0) && (ident_q == sel_q)) begin
            sel_d               = '0;
            ev_d[EV_DESELECTED] = ev_q[EV_DESELECTED] + CTR_W'(1);
            ok                  = 1'b1;
          end else begin
            ev_d[EV_BAD_DESELECT] = ev_q[EV_BAD_DESELECT] + CTR_W'(1);
          end
        end
        MODE_ACTIVE: begin
          if ((ident_q != '0) && (ident_q == sel_q)) begin
            ok = 1'b1;
          end else begin
            ev_d[EV_NOT_ACTIVE] = ev_q[EV_NOT_ACTIVE] + CTR_W'(1);
          end
        end
        MODE_ACK: begin
          if (hit_q) begin
            ok = 1'b1;
          end else begin
            ev_d[EV_NOT_MEMBER] = ev_q[EV_NOT_MEMBER] + CTR_W'(1);
          end
        end
        MODE_CLEAR: begin
          ev_d[EV_REMOVED] = ev_q[EV_REMOVED] + CTR_W'(count_q);
          valid_d          = '0;
          count_d          = '0;
          sel_d            = '0;
          ok               = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // Result slot: filled on commit, emptied when the sink takes it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.commit) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Set state, counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      sel_q     <= '0;
      count_q   <= '0;
      ev_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      sel_q     <= sel_d;
      count_q   <= count_d;
      ev_q      <= ev_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload, taken from the state after the step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.accepted          <= ok;
      rsp_q.table_full        <= full;
      rsp_q.current_selection <= sel_d;
      rsp_q.member_count      <= MCNT_W'(count_d);
      rsp_q.totals            <= ev_d;
    end
  end

  // Status for the controller.
  assign mode_in           = mode_e'(mode_i);
  assign sts_o.needs_scan  = (mode_in != MODE_DESELECT) && (mode_in != MODE_ACTIVE) &&
                             (mode_in != MODE_CLEAR);
  assign sts_o.scan_last   = (scan_idx_q == IDX_W'(CAPACITY - 1));
  assign sts_o.out_free    = !out_vld_q || rsp_o.ready;

  // Result channel.
  assign rsp_o.valid              = out_vld_q;
  assign rsp_o.accepted           = rsp_q.accepted;
  assign rsp_o.table_full         = rsp_q.table_full;
  assign rsp_o.current_selection  = rsp_q.current_selection;
  assign rsp_o.member_count       = rsp_q.member_count;
  assign rsp_o.added_total        = rsp_q.totals[EV_ADDED];
  assign rsp_o.removed_total      = rsp_q.totals[EV_REMOVED];
  assign rsp_o.selected_total     = rsp_q.totals[EV_SELECTED];
  assign rsp_o.deselected_total   = rsp_q.totals[EV_DESELECTED];
  assign rsp_o.bad_select_total   = rsp_q.totals[EV_BAD_SELECT];
  assign rsp_o.bad_deselect_total = rsp_q.totals[EV_BAD_DESELECT];
  assign rsp_o.not_active_total   = rsp_q.totals[EV_NOT_ACTIVE];
  assign rsp_o.not_member_total   = rsp_q.totals[EV_NOT_MEMBER];

endmodule

`default_nettype wire

### src/mss_ctrl.sv
// Controller: sequences request capture, table scan and commit.
`default_nettype none

module mss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire mss_pkg::sts_t sts_i,
  output logic               req_ready_o,
  output mss_pkg::cmd_t      cmd_o
);
  import mss_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.needs_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read returns and is compared in this cycle.
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/member_set_with_selection_unit.sv
// Top level of the member set unit with its selection and event counters.
`default_nettype none
`include "member_set_with_selection_unit_defines.svh"

// Holds up to CAPACITY distinct 64-bit identifiers and one selected
// identifier (zero means none), and answers one request at a time with one
// result carrying the status, the selection, the member count and eight
// wrapping event totals. Requests that look up the table (add, remove, test,
// select, ack permission) walk the identifier RAM through its single read
// port, one entry per cycle, in the scan state, then pass through drain and
// commit. Deselect, active check and clear go from acceptance straight to the
// commit state. A result sits in an output register until taken; the next
// request is accepted meanwhile and waits at commit only if the previous
// result has still not been taken. An add into a full table is refused
// with table_full set and changes nothing.
module member_set_with_selection_unit (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  mss_req_if.sink   req_i,
  mss_rsp_if.source rsp_o
);
  import mss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  mss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  // Table, selection, counters and result register.
  mss_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (req_i.mode),
    .ident_i (req_i.ident),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .rsp_o   (rsp_o)
  );

  // One request in flight: acceptance closes the request channel.
  `MSS_ASSERT_NXT(a_one_in_flight, req_i.valid && req_i.ready, !req_i.ready)
  // A commit never overwrites a result that has not been taken.
  `MSS_ASSERT_IMP(a_commit_slot_free, cmd.commit, sts.out_free)
  // A refused add is never reported as accepted.
  `MSS_ASSERT_IMP(a_full_not_ok, rsp_o.valid && rsp_o.table_full, !rsp_o.accepted)
  // A refused add only happens with every slot in use.
  `MSS_ASSERT_IMP(a_full_count, rsp_o.valid && rsp_o.table_full,
                  rsp_o.member_count == MCNT_W'(CAPACITY))

endmodule

`default_nettype wire
